>>> hw/rtl/stm_pkg.sv
// Shared types and constants of the software timer bank.
`default_nettype none

package stm_pkg;

  localparam int unsigned TIMER_SLOTS = 8;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned RES_ID_W    = 16;
  localparam int unsigned CMP_W       = (ID_BITS > RES_ID_W) ? ID_BITS : RES_ID_W;
  localparam int unsigned STEP_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_STOP = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    KIND_FIRED    = 3'd0,
    KIND_ADDED    = 3'd1,
    KIND_REFUSED  = 3'd2,
    KIND_STOPPED  = 3'd3,
    KIND_NOTFOUND = 3'd4,
    KIND_DONE     = 3'd5
  } kind_e;

  // One timer slot.
  typedef struct packed {
    logic                valid;
    logic [ID_BITS-1:0]  ident;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   stamp;
    logic                single;
  } entry_t;

  // Shift controls broadcast to every cell.
  typedef struct packed {
    logic rot;   // ring step: every cell takes its upper neighbor
    logic sqz;   // compaction step: cells at or above the first hole shift down
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/stm_req_if.sv
// Request channel: one word per tick, add or stop command.
`default_nettype none

interface stm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] now_ms;
  logic [15:0] period_ms;
  logic        one_shot;
  logic [15:0] timer_id;

  modport source (output valid, op, now_ms, period_ms, one_shot, timer_id, input ready);
  modport sink   (input valid, op, now_ms, period_ms, one_shot, timer_id, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stm_rsp_if.sv
// Response channel: one word per result.
`default_nettype none

interface stm_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] result_id;
  logic        last;

  modport source (output valid, kind, result_id, last, input ready);
  modport sink   (input valid, kind, result_id, last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stm_cfg_if.sv
// Configuration write channel carrying the enable register.
`default_nettype none

interface stm_cfg_if;
  logic valid;
  logic ready;
  logic enable;

  modport source (output valid, enable, input ready);
  modport sink   (input valid, enable, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/stm_cell.sv
// One timer slot of the chain; loads from its upper neighbor on a shift.
`default_nettype none

module stm_cell (
  input  wire                logic  clk_i,
  input  wire                logic  rst_ni,
  input  stm_pkg::cell_ctl_t        ctl_i,
  input  wire                logic  hole_i,
  input  stm_pkg::entry_t           nbr_i,
  output stm_pkg::entry_t           entry_o,
  output logic                      hole_o
);

  logic            valid_q;
  stm_pkg::entry_t data_q;
  logic            load;

  // A hole at or below this cell lets the compaction step pull data down
  assign hole_o = hole_i | ~valid_q;
  assign load   = ctl_i.rot | (ctl_i.sqz & hole_o);

  // Hold the valid bit under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= nbr_i.valid;
    end
  end

  // Hold the slot payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= nbr_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule

`default_nettype wire

>>> hw/rtl/software_timer_bank.sv
// Software timer bank: a ring of timer cells walked by one head processor.
// Each tick, add or stop passes, from acceptance to the next acceptance, through
// TIMER_SLOTS ring steps via the head, TIMER_SLOTS compaction steps, the final
// word and the idle state in which the next request is accepted.
// Fired words leave during the ring steps; a stalled response port stalls the ring.
// Reset (asynchronous, active low) empties all slots and sets enable to 1.
`default_nettype none

module software_timer_bank (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  stm_cfg_if.sink    cfg_i,
  stm_req_if.sink    req_i,
  stm_rsp_if.source  rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_SQZ  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_e;

  state_e                          state_q;
  logic [stm_pkg::STEP_W-1:0]      cnt_q;
  logic                            enable_q;

  logic [1:0]                      op_q;
  logic [stm_pkg::TIME_W-1:0]      now_q;
  logic [stm_pkg::PERIOD_W-1:0]    intv_q;
  logic                            single_q;
  logic [stm_pkg::RES_ID_W-1:0]    want_q;

  logic                            found_q;
  logic                            added_q;
  logic                            seen_q;
  logic [stm_pkg::ID_BITS-1:0]     last_id_q;
  logic [stm_pkg::ID_BITS-1:0]     new_id_q;
  logic [stm_pkg::ID_BITS-1:0]     res_id_q;

  logic                            rsp_v_q;
  logic [2:0]                      rsp_kind_q;
  logic [stm_pkg::RES_ID_W-1:0]    rsp_id_q;
  logic                            rsp_last_q;

  stm_pkg::entry_t                 ent [stm_pkg::TIMER_SLOTS];
  logic                            hole [stm_pkg::TIMER_SLOTS+1];
  stm_pkg::entry_t                 head;
  stm_pkg::entry_t                 tail;
  stm_pkg::entry_t                 tail_in;
  stm_pkg::cell_ctl_t              ctl;

  logic                            go;
  logic                            step_last;
  logic                            accept;
  logic                            op_known;
  logic [stm_pkg::TIME_W-1:0]      elapsed;
  logic                            due;
  logic [stm_pkg::ID_BITS-1:0]     inc_id;
  logic [stm_pkg::ID_BITS-1:0]     new_id;
  logic                            match;
  logic                            fire;
  logic                            take_add;
  logic                            take_stop;
  logic                            load_fire;
  logic                            load_fin;
  logic [2:0]                      fin_kind;
  logic [stm_pkg::RES_ID_W-1:0]    fin_id;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid & req_i.ready;
  assign op_known    = (req_i.op == stm_pkg::OP_TICK) || (req_i.op == stm_pkg::OP_ADD) ||
                       (req_i.op == stm_pkg::OP_STOP);

  assign go        = ~rsp_v_q | rsp_o.ready;
  assign step_last = (cnt_q == stm_pkg::STEP_W'(stm_pkg::TIMER_SLOTS - 1));

  // Cell chain: the head leaves at slot 0, the processed word enters at the top
  assign hole[0] = 1'b0;
  assign ctl.rot = (state_q == ST_ROT) & go;
  assign ctl.sqz = (state_q == ST_SQZ);
  assign tail_in = (state_q == ST_SQZ) ? '0 : tail;

  for (genvar i = 0; i < stm_pkg::TIMER_SLOTS; i++) begin : g_cell
    stm_pkg::entry_t nbr;
    if (i == stm_pkg::TIMER_SLOTS - 1) begin : g_top
      assign nbr = tail_in;
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    stm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .hole_i  (hole[i]),
      .nbr_i   (nbr),
      .entry_o (ent[i]),
      .hole_o  (hole[i+1])
    );
  end

  // Head processing
  assign head    = ent[0];
  assign elapsed = now_q - head.stamp;
  assign due     = (elapsed >= stm_pkg::TIME_W'(head.period));
  assign inc_id  = last_id_q + 1'b1;
  assign new_id  = (!seen_q || inc_id == '0) ? stm_pkg::ID_BITS'(1) : inc_id;
  assign match   = (stm_pkg::CMP_W'(head.ident) == stm_pkg::CMP_W'(want_q));

  always_comb begin
    tail      = head;
    fire      = 1'b0;
    take_add  = 1'b0;
    take_stop = 1'b0;
    case (op_q)
      stm_pkg::OP_TICK: begin
        if (enable_q && head.valid && due) begin
          fire       = 1'b1;
          tail.stamp = now_q;
          if (head.single) begin
            tail.valid = 1'b0;
          end
        end
      end
      stm_pkg::OP_ADD: begin
        if (enable_q && !head.valid && !added_q) begin
          take_add    = 1'b1;
          tail.valid  = 1'b1;
          tail.ident  = new_id;
          tail.period = intv_q;
          tail.stamp  = now_q;
          tail.single = single_q;
        end
      end
      stm_pkg::OP_STOP: begin
        if (enable_q && want_q != '0 && !found_q && head.valid && match) begin
          take_stop  = 1'b1;
          tail.valid = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Final word of the item
  always_comb begin
    fin_kind = stm_pkg::KIND_DONE;
    fin_id   = '0;
    case (op_q)
      stm_pkg::OP_ADD: begin
        fin_kind = added_q ? stm_pkg::KIND_ADDED : stm_pkg::KIND_REFUSED;
        fin_id   = added_q ? stm_pkg::RES_ID_W'(new_id_q) : '0;
      end
      stm_pkg::OP_STOP: begin
        fin_kind = found_q ? stm_pkg::KIND_STOPPED : stm_pkg::KIND_NOTFOUND;
        fin_id   = found_q ? stm_pkg::RES_ID_W'(res_id_q) : '0;
      end
      default: ;
    endcase
  end

  assign load_fire = ctl.rot & fire;
  assign load_fin  = (state_q == ST_FIN) & go;

  // Enable register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      enable_q <= cfg_i.enable;
    end
  end

  // Sequencer and per-item flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      found_q <= 1'b0;
      added_q <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && op_known) begin
            state_q <= ST_ROT;
            cnt_q   <= '0;
            found_q <= 1'b0;
            added_q <= 1'b0;
            seen_q  <= 1'b0;
          end
        end
        ST_ROT: begin
          if (go) begin
            if (take_add) begin
              added_q <= 1'b1;
            end
            if (take_stop) begin
              found_q <= 1'b1;
            end
            if (head.valid) begin
              seen_q <= 1'b1;
            end
            cnt_q <= cnt_q + 1'b1;
            if (step_last) begin
              cnt_q   <= '0;
              state_q <= ST_SQZ;
            end
          end
        end
        ST_SQZ: begin
          cnt_q <= cnt_q + 1'b1;
          if (step_last) begin
            cnt_q   <= '0;
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (go) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Latch the request word and head results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= req_i.op;
      now_q    <= req_i.now_ms;
      intv_q   <= req_i.period_ms;
      single_q <= req_i.one_shot;
      want_q   <= req_i.timer_id;
    end
    if (ctl.rot && head.valid) begin
      last_id_q <= head.ident;
    end
    if (ctl.rot && take_add) begin
      new_id_q <= new_id;
    end
    if (ctl.rot && take_stop) begin
      res_id_q <= head.ident;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_v_q <= 1'b0;
    end else if (load_fire || load_fin) begin
      rsp_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_fire) begin
      rsp_kind_q <= stm_pkg::KIND_FIRED;
      rsp_id_q   <= stm_pkg::RES_ID_W'(head.ident);
      rsp_last_q <= 1'b0;
    end else if (load_fin) begin
      rsp_kind_q <= fin_kind;
      rsp_id_q   <= fin_id;
      rsp_last_q <= 1'b1;
    end
  end

  assign rsp_o.valid     = rsp_v_q;
  assign rsp_o.kind      = rsp_kind_q;
  assign rsp_o.result_id = rsp_id_q;
  assign rsp_o.last      = rsp_last_q;

endmodule

`default_nettype wire

>>> hw/rtl/stm_chk.sv
// Port-level checks of the software timer bank, bound to the top level.
`default_nettype none

module stm_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        req_valid_i,
  input wire logic        req_ready_i,
  input wire logic [1:0]  req_op_i,
  input wire logic        rsp_valid_i,
  input wire logic        rsp_ready_i,
  input wire logic [2:0]  rsp_kind_i,
  input wire logic [15:0] rsp_result_id_i,
  input wire logic        rsp_last_i
);

  // Stalled response word holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_kind_i) &&
      $stable(rsp_result_id_i) && $stable(rsp_last_i))
    else $error("response word changed while stalled");

  // A command in progress blocks the request port
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_op_i == stm_pkg::OP_TICK ||
      req_op_i == stm_pkg::OP_ADD || req_op_i == stm_pkg::OP_STOP) |=> !req_ready_i)
    else $error("request taken while a command is in progress");

  // Only fired words come before the closing word
  a_mid_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_last_i |-> rsp_kind_i == stm_pkg::KIND_FIRED)
    else $error("non-final word is not a fired word");

  a_fired_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_kind_i == stm_pkg::KIND_FIRED |-> !rsp_last_i)
    else $error("fired word marked last");

  // Words without a timer carry id zero
  a_zero_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_kind_i == stm_pkg::KIND_REFUSED ||
      rsp_kind_i == stm_pkg::KIND_NOTFOUND || rsp_kind_i == stm_pkg::KIND_DONE)
      |-> rsp_result_id_i == '0)
    else $error("id set on a word without a timer");

endmodule

bind software_timer_bank stm_chk u_stm_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .req_op_i        (req_i.op),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_kind_i      (rsp_o.kind),
  .rsp_result_id_i (rsp_o.result_id),
  .rsp_last_i      (rsp_o.last)
);

`default_nettype wire
